// ===== design/assert_macros.svh =====
// Assertion helpers included by the distance unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, suspended while reset is active.
`define PSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same, for a property that is only meaningful once reset is released.
`define PSP_ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("run-time check failed");

`endif

// ===== design/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg
// Types and constants of the path stop point distance unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psp_pkg;

    localparam int COORD_W = 24;
    localparam int MAG_W   = COORD_W + 1;     // |dx|, |dy| up to 2^24 - 1
    localparam int SQ_W    = 2 * MAG_W;       // dx^2 + dy^2, even width
    localparam int ROOT_W  = SQ_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int CNT_W   = $clog2(ROOT_W);
    localparam int LEN_W   = 32;
    localparam int DIST_W  = 33;
    localparam int VEL_W   = 16;
    localparam int OBS_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_IDX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_VEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_SPEED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUMPER     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_MARGIN = 3'd6;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_SIGNAL   = 2'd1;
    localparam logic [1:0] KIND_TEMP     = 2'd2;
    localparam logic [1:0] KIND_OBSTACLE = 2'd3;

    localparam logic [1:0] LIGHT_RED = 2'd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      signal_line;
        logic                      temp_line;
        logic                      last_point;
    } t_in_word;

    typedef struct packed {
        logic signed [DIST_W-1:0] stop_distance;
        logic [1:0]               stop_kind;
        logic [VEL_W-1:0]         target_velocity;
    } t_out_word;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_START,
        S_ROOT,
        S_UPDATE
    } t_state;

endpackage

// ===== design/psp_isqrt.sv =====
// ----------------------------------------------------------------------------
// psp_isqrt
// Iterative integer square root, rounded down, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psp_isqrt import psp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQ_W-1:0] i_radicand,
    output t_sqrt_stat      o_stat
);

    logic [SQ_W-1:0]   r_rad,  n_rad;
    logic [REM_W-1:0]  r_rem,  n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;

    always_comb begin
        cur    = {r_rem, r_rad[SQ_W-1 -: 2]};
        trial  = (REM_W + 2)'({r_root, 2'b01});
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_W'(ROOT_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[SQ_W-3:0], 2'b00};
            if (cur >= trial) begin
                n_rem  = REM_W'(cur - trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(cur);
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
    end

    assign o_stat.done = r_done;
    assign o_stat.root = r_root;

endmodule

// ===== design/path_stop_point_distance_unit.sv =====
// ----------------------------------------------------------------------------
// path_stop_point_distance_unit
// Sums segment lengths of a path and reports the distance to its stop point.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  in        input      i_in_valid / o_in_stall   t_in_word  (one waypoint)
//  out       output     o_out_valid / i_out_stall t_out_word (one per path)
//  cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  A waypoint holds the input off while it passes through its steps:
//  difference, two squaring steps on the shared multiplier, a root start,
//  the root iterations, a done step and an update.
//  A path's first waypoint skips the arithmetic. Reset is synchronous, active
//  low, and gives the register reset values and an empty path. A stalled
//  result waits in the output register; the next waypoint is still taken and
//  only the following last waypoint waits in the update step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module path_stop_point_distance_unit import psp_pkg::*; #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (IDX_W > OBS_W - 1) ? IDX_W : OBS_W - 1;
    localparam int OFF_W = VEL_W + 1;

    // configuration
    logic [1:0]       r_light;
    logic             r_temp_en;
    logic [OBS_W-1:0] r_obs_idx;
    logic [VEL_W-1:0] r_temp_vel;
    logic [VEL_W-1:0] r_obs_speed;
    logic [VEL_W-1:0] r_bumper;
    logic [VEL_W-1:0] r_margin;

    // path state
    t_state                   r_state, n_state;
    t_in_word                 r_word;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic [LEN_W-1:0]         r_len;
    logic [IDX_W-1:0]         r_point_idx;
    logic                     r_match;
    logic signed [DIST_W-1:0] r_held_dist;
    logic [1:0]               r_held_kind;
    logic [VEL_W-1:0]         r_held_vel;
    logic [MAG_W-1:0]         r_mag_x, r_mag_y;
    logic [SQ_W-1:0]          r_sq;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic                     in_accept;
    logic                     sq_start;
    t_sqrt_stat               sq_stat;
    logic                     upd_go;
    logic                     res_load;
    logic signed [MAG_W-1:0]  dx, dy;
    logic [MAG_W-1:0]         mul_op;
    logic [SQ_W-1:0]          prod;
    logic [LEN_W:0]           len_sum;
    logic [LEN_W-1:0]         new_len;
    logic                     obs_hit;
    logic [1:0]               hit_kind;
    logic [OFF_W-1:0]         hit_off;
    logic [VEL_W-1:0]         hit_vel;
    logic [LEN_W+1:0]         hit_diff;
    logic signed [DIST_W-1:0] hit_dist;
    logic signed [DIST_W-1:0] fin_dist;
    logic [1:0]               fin_kind;
    logic [VEL_W-1:0]         fin_vel;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    psp_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_sq),
        .o_stat     (sq_stat)
    );

    // segment arithmetic
    always_comb begin
        dx      = MAG_W'(r_word.pos_x) - MAG_W'(r_prev_x);
        dy      = MAG_W'(r_word.pos_y) - MAG_W'(r_prev_y);
        mul_op  = (r_state == S_SQX) ? r_mag_x : r_mag_y;
        prod    = SQ_W'(mul_op) * SQ_W'(mul_op);
        len_sum = (LEN_W + 1)'(r_len) + (LEN_W + 1)'(sq_stat.root);
        new_len = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
    end

    // stop rules, priority signal, temporary, obstacle
    always_comb begin
        obs_hit = !r_obs_idx[OBS_W-1] && (r_obs_idx != '0)
                  && (r_point_idx != IDX_W'(MAX_POINTS))
                  && (CMP_W'(r_obs_idx[OBS_W-2:0]) == CMP_W'(r_point_idx));
        hit_kind = KIND_NONE;
        hit_off  = OFF_W'(r_bumper);
        hit_vel  = '0;
        if (r_word.signal_line && r_light == LIGHT_RED) begin
            hit_kind = KIND_SIGNAL;
        end else if (r_word.temp_line && r_temp_en) begin
            hit_kind = KIND_TEMP;
            hit_vel  = r_temp_vel;
        end else if (obs_hit) begin
            hit_kind = KIND_OBSTACLE;
            hit_off  = OFF_W'(r_bumper) + OFF_W'(r_margin);
            hit_vel  = r_obs_speed;
        end
        hit_diff = (LEN_W + 2)'(new_len) - (LEN_W + 2)'(hit_off);
        hit_dist = hit_diff[LEN_W+1] ? '0 : hit_diff[DIST_W-1:0];

        fin_dist = r_held_dist;
        fin_kind = r_held_kind;
        fin_vel  = r_held_vel;
        if (r_point_idx != '0 && !r_match && hit_kind != KIND_NONE) begin
            fin_dist = hit_dist;
            fin_kind = hit_kind;
            fin_vel  = hit_vel;
        end
    end

    // a last waypoint waits while the previous result is still held
    assign upd_go   = !r_word.last_point || !r_out_valid || !i_out_stall;
    assign res_load = (r_state == S_UPDATE) && upd_go && r_word.last_point;

    always_comb begin
        n_state  = r_state;
        sq_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (r_point_idx == '0) ? S_UPDATE : S_DIFF;
                end
            end
            S_DIFF:  n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_START;
            S_START: begin
                sq_start = 1'b1;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                if (sq_stat.done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light     <= 2'd1;
            r_temp_en   <= 1'b0;
            r_obs_idx   <= '1;
            r_temp_vel  <= '0;
            r_obs_speed <= '0;
            r_bumper    <= VEL_W'(4550);
            r_margin    <= VEL_W'(4000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIGHT:      r_light     <= i_cfg_data[1:0];
                CFG_TEMP_EN:    r_temp_en   <= i_cfg_data[0];
                CFG_OBS_IDX:    r_obs_idx   <= i_cfg_data[OBS_W-1:0];
                CFG_TEMP_VEL:   r_temp_vel  <= i_cfg_data;
                CFG_OBS_SPEED:  r_obs_speed <= i_cfg_data;
                CFG_BUMPER:     r_bumper    <= i_cfg_data;
                CFG_OBS_MARGIN: r_margin    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath scratch registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_word <= i_in_word;
        end
        if (r_state == S_DIFF) begin
            r_mag_x <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            r_mag_y <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        end
        if (r_state == S_SQX) begin
            r_sq <= prod;
        end else if (r_state == S_SQY) begin
            r_sq <= r_sq + prod;
        end
        if (res_load) begin
            r_out_word.stop_distance   <= fin_dist;
            r_out_word.stop_kind       <= fin_kind;
            r_out_word.target_velocity <= fin_vel;
        end
    end

    // path state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_len       <= '0;
            r_point_idx <= '0;
            r_match     <= 1'b0;
            r_held_dist <= '1;
            r_held_kind <= KIND_NONE;
            r_held_vel  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace one taken at the same edge
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_UPDATE && upd_go) begin
                if (r_word.last_point) begin
                    r_prev_x    <= '0;
                    r_prev_y    <= '0;
                    r_len       <= '0;
                    r_point_idx <= '0;
                    r_match     <= 1'b0;
                    r_held_dist <= '1;
                    r_held_kind <= KIND_NONE;
                    r_held_vel  <= '0;
                end else begin
                    r_prev_x <= r_word.pos_x;
                    r_prev_y <= r_word.pos_y;
                    if (r_point_idx != '0) begin
                        r_len <= new_len;
                        if (!r_match && hit_kind != KIND_NONE) begin
                            r_match <= 1'b1;
                        end
                    end
                    if (r_point_idx != IDX_W'(MAX_POINTS)) begin
                        r_point_idx <= r_point_idx + 1'b1;
                    end
                    r_held_dist <= fin_dist;
                    r_held_kind <= fin_kind;
                    r_held_vel  <= fin_vel;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `PSP_ASSERT(a_root_done_in_wait, i_clk, i_rst_n, sq_stat.done |-> r_state == S_ROOT)
    `PSP_ASSERT(a_result_from_last, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(res_load))
    `PSP_ASSERT_RUN(a_held_none, i_clk, i_rst_n, !r_match |-> r_held_kind == KIND_NONE && &r_held_dist)
    `PSP_ASSERT_RUN(a_held_kind, i_clk, i_rst_n, r_match |-> r_held_kind != KIND_NONE && r_held_dist >= 0)

endmodule

// ===== sim/path_stop_point_distance_unit_tb.sv =====
// ----------------------------------------------------------------------------
// path_stop_point_distance_unit_tb
// Drives waypoint paths into the stop point unit and checks every per-path
// result against an in-bench model of length summing and stop selection.
// Covers directed stop rules, saturation, long paths, backpressure and
// randomized paths under a range of register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_stop_point_distance_unit_tb;
    import psp_pkg::*;

    localparam int MAX_POINTS    = 4096;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_POINTS  = 140;
    localparam int LONG_POINTS   = 400;
    localparam int LONG_OBS      = 350;
    localparam int FINAL_WAIT    = 20000;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    path_stop_point_distance_unit #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // register mirror, reset values
    logic [1:0]       cfg_light     = 2'd1;
    logic             cfg_temp_en   = 1'b0;
    logic [OBS_W-1:0] cfg_obs_idx   = '1;
    logic [VEL_W-1:0] cfg_temp_vel  = '0;
    logic [VEL_W-1:0] cfg_obs_speed = '0;
    logic [15:0]      cfg_bumper    = 16'd4550;
    logic [15:0]      cfg_margin    = 16'd4000;

    // path tracking state
    logic signed [COORD_W-1:0] trk_prev_x = '0;
    logic signed [COORD_W-1:0] trk_prev_y = '0;
    longint unsigned           trk_len    = 0;
    int unsigned               trk_idx    = 0;
    bit                        trk_hit    = 1'b0;
    logic signed [DIST_W-1:0]  hit_dist   = '1;
    logic [1:0]                hit_kind   = KIND_NONE;
    logic [VEL_W-1:0]          hit_vel    = '0;

    t_out_word   pending_stops[$];
    int unsigned fail_count    = 0;
    int unsigned sent_count    = 0;
    int unsigned paths_checked = 0;
    int unsigned kinds_seen[4] = '{0, 0, 0, 0};
    int unsigned rx_hold_cycles = 0;
    int unsigned tx_calm_left   = 0;
    bit          tx_gaps_on     = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("path_stop_point_distance_unit verification failed");
        $finish;
    end

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= n) r = b;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    function automatic int unsigned next_tx_gap();
        if (!tx_gaps_on) return 0;
        if (tx_calm_left != 0) begin
            tx_calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) tx_calm_left = $urandom_range(20, 60);
        return ($urandom_range(0, 99) < 60) ? 0 : pick_gap_len();
    endfunction

    function automatic t_in_word mk_wp(input int x, input int y,
                                       input bit sig, input bit tmp, input bit last);
        t_in_word w;
        w.pos_x       = x[COORD_W-1:0];
        w.pos_y       = y[COORD_W-1:0];
        w.signal_line = sig;
        w.temp_line   = tmp;
        w.last_point  = last;
        return w;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    task automatic capture_stop(input logic [1:0] kind, input longint offset,
                                input logic [VEL_W-1:0] vel);
        longint d;
        d = longint'(trk_len) - offset;
        hit_dist = (d < 0) ? '0 : d[DIST_W-1:0];
        hit_kind = kind;
        hit_vel  = vel;
        trk_hit  = 1'b1;
    endtask

    // Advances the path model by one accepted waypoint; queues a result on last.
    task automatic track_waypoint(input t_in_word w);
        longint    dx;
        longint    dy;
        bit        obs_pos;
        t_out_word res;
        if (trk_idx != 0) begin
            dx = longint'(w.pos_x) - longint'(trk_prev_x);
            dy = longint'(w.pos_y) - longint'(trk_prev_y);
            trk_len += floor_root(dx * dx + dy * dy);
            if (trk_len > 64'hFFFF_FFFF) trk_len = 64'hFFFF_FFFF;
            if (!trk_hit) begin
                obs_pos = !cfg_obs_idx[OBS_W-1] && (cfg_obs_idx != 0);
                if (w.signal_line && cfg_light == LIGHT_RED)
                    capture_stop(KIND_SIGNAL, longint'(cfg_bumper), '0);
                else if (w.temp_line && cfg_temp_en)
                    capture_stop(KIND_TEMP, longint'(cfg_bumper), cfg_temp_vel);
                else if (obs_pos && trk_idx < MAX_POINTS && cfg_obs_idx == trk_idx)
                    capture_stop(KIND_OBSTACLE,
                                 longint'(cfg_bumper) + longint'(cfg_margin),
                                 cfg_obs_speed);
            end
        end
        trk_prev_x = w.pos_x;
        trk_prev_y = w.pos_y;
        if (trk_idx < MAX_POINTS) trk_idx++;
        if (w.last_point) begin
            res.stop_distance   = hit_dist;
            res.stop_kind       = hit_kind;
            res.target_velocity = hit_vel;
            pending_stops.push_back(res);
            trk_prev_x = '0;
            trk_prev_y = '0;
            trk_len    = 0;
            trk_idx    = 0;
            trk_hit    = 1'b0;
            hit_dist   = '1;
            hit_kind   = KIND_NONE;
            hit_vel    = '0;
        end
    endtask

    task automatic send_waypoint(input t_in_word w);
        int unsigned gap;
        gap = next_tx_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_waypoint(w);
        sent_count++;
    endtask

    // Sender goes quiet until every queued result is back, then lets the unit settle.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_stops.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_LIGHT:      cfg_light     = data[1:0];
            CFG_TEMP_EN:    cfg_temp_en   = data[0];
            CFG_OBS_IDX:    cfg_obs_idx   = data[OBS_W-1:0];
            CFG_TEMP_VEL:   cfg_temp_vel  = data;
            CFG_OBS_SPEED:  cfg_obs_speed = data;
            CFG_BUMPER:     cfg_bumper    = data;
            CFG_OBS_MARGIN: cfg_margin    = data;
            default: ;
        endcase
    endtask

    task automatic set_all_regs(input logic [15:0] light, input logic [15:0] temp_en,
                                input logic [15:0] obs_idx, input logic [15:0] temp_vel,
                                input logic [15:0] obs_speed, input logic [15:0] bumper,
                                input logic [15:0] margin);
        write_reg(CFG_LIGHT, light);
        write_reg(CFG_TEMP_EN, temp_en);
        write_reg(CFG_OBS_IDX, obs_idx);
        write_reg(CFG_TEMP_VEL, temp_vel);
        write_reg(CFG_OBS_SPEED, obs_speed);
        write_reg(CFG_BUMPER, bumper);
        write_reg(CFG_OBS_MARGIN, margin);
    endtask

    function automatic int pick_coord(input int style, input int prev);
        case (style)
            0: return prev + int'($urandom_range(0, 4000)) - 2000;
            1: begin
                case ($urandom_range(0, 4))
                    0: return -8388608;
                    1: return 8388607;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return int'($urandom);
        endcase
    endfunction

    // Reset register values: lines are ignored, single point path gives no stop.
    task automatic test_reset_defaults();
        send_waypoint(mk_wp(5, 5, 1, 1, 1));
        send_waypoint(mk_wp(0, 0, 1, 1, 0));
        send_waypoint(mk_wp(300, 400, 1, 1, 0));
        send_waypoint(mk_wp(600, 800, 1, 0, 1));
        drain_results();
    endtask

    task automatic test_stop_rules();
        set_all_regs(LIGHT_RED, 1, 3, 16'hFFFF, 16'h1234, 4550, 4000);
        // signal wins over temporary; first point lines never count
        send_waypoint(mk_wp(0, 0, 1, 1, 0));
        send_waypoint(mk_wp(3000, 4000, 1, 1, 0));
        send_waypoint(mk_wp(8388607, -8388608, 0, 0, 1));
        // temporary, later lines ignored once a stop is held
        send_waypoint(mk_wp(100, 100, 0, 0, 0));
        send_waypoint(mk_wp(100, 20100, 0, 1, 0));
        send_waypoint(mk_wp(0, 0, 1, 0, 1));
        // obstacle at index 3
        send_waypoint(mk_wp(0, 0, 0, 0, 0));
        send_waypoint(mk_wp(0, 6000, 0, 0, 0));
        send_waypoint(mk_wp(0, 12000, 0, 0, 0));
        send_waypoint(mk_wp(0, 30000, 0, 0, 0));
        send_waypoint(mk_wp(5, 5, 0, 0, 1));
        drain_results();
        // distance below the bumper offset clamps to zero; then coordinate extremes
        write_reg(CFG_BUMPER, 16'hFFFF);
        send_waypoint(mk_wp(0, 0, 0, 0, 0));
        send_waypoint(mk_wp(1, 1, 1, 0, 1));
        send_waypoint(mk_wp(-8388608, 8388607, 0, 0, 0));
        send_waypoint(mk_wp(8388607, -8388608, 1, 0, 1));
        drain_results();
        // obstacle index zero is not a match, light not red, temporary off
        set_all_regs(3, 0, 0, 0, 0, 4550, 4000);
        send_waypoint(mk_wp(0, 0, 1, 1, 0));
        send_waypoint(mk_wp(10, 0, 1, 1, 0));
        send_waypoint(mk_wp(20, 0, 1, 1, 1));
        drain_results();
    endtask

    task automatic test_length_saturation();
        set_all_regs(LIGHT_RED, 0, 16'h1FFF, 0, 0, 0, 0);
        for (int i = 0; i < 190; i++) begin
            if (i[0]) send_waypoint(mk_wp(8388607, 8388607, i == 189, 0, i == 189));
            else send_waypoint(mk_wp(-8388608, -8388608, 0, 0, 0));
        end
        drain_results();
    endtask

    task automatic run_long_path(input int unsigned n, input int unsigned sig_at);
        int x;
        int y;
        x = 0;
        y = 0;
        for (int unsigned i = 0; i < n; i++) begin
            x = x + int'($urandom_range(0, 1000)) - 500;
            y = y + int'($urandom_range(0, 1000)) - 500;
            send_waypoint(mk_wp(x, y, i == sig_at, i == sig_at, i == n - 1));
        end
        drain_results();
    endtask

    // Obstacle deep in a long path; late stop lines ignored with light not red and temporary off.
    task automatic test_long_paths();
        set_all_regs(1, 0, LONG_OBS, 0, 16'd777, 100, 200);
        run_long_path(LONG_POINTS, LONG_POINTS - 2);
    endtask

    task automatic send_short_paths(input int unsigned count);
        for (int unsigned p = 0; p < count; p++) begin
            send_waypoint(mk_wp(0, 0, 0, 0, 0));
            send_waypoint(mk_wp(p * 100, 700, 1, 0, 0));
            send_waypoint(mk_wp(p * 100, 1400, 0, 1, 1));
        end
    endtask

    task automatic test_backpressure();
        set_all_regs(LIGHT_RED, 1, 2, 16'd50, 16'd60, 10, 20);
        tx_gaps_on = 1'b0;
        rx_hold_cycles = 600;
        send_short_paths(6);
        while (rx_hold_cycles != 0) @(posedge i_clk);
        drain_results();
        send_short_paths(2);
        tx_gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_paths();
        int unsigned phase_points;
        int unsigned len;
        int          style;
        int          x;
        int          y;
        int unsigned r;
        logic [15:0] obs;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_all_regs(0, 0, 0, 0, 0, 0, 0);
                1: set_all_regs(3, 1, MAX_POINTS - 1, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF);
                2: set_all_regs(LIGHT_RED, 1, 16'h1FFF, $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 8000),
                                $urandom_range(0, 8000));
                default: begin
                    r = $urandom_range(0, 6);
                    obs = (r == 0) ? 16'h1FFF : (r == 1) ? 16'h0000 :
                          (r == 6) ? 16'($urandom_range(1, MAX_POINTS - 1)) :
                          16'($urandom_range(1, 12));
                    set_all_regs($urandom_range(0, 1) ? LIGHT_RED : $urandom_range(1, 3),
                                 $urandom_range(0, 1), obs, $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 20000),
                                 $urandom_range(0, 20000));
                end
            endcase
            phase_points = 0;
            while (phase_points < PHASE_POINTS) begin
                r = $urandom_range(0, 99);
                len = (r < 70) ? $urandom_range(1, 8) :
                      (r < 95) ? $urandom_range(9, 30) : $urandom_range(31, 80);
                style = $urandom_range(0, 2);
                x = int'($urandom_range(0, 20000)) - 10000;
                y = int'($urandom_range(0, 20000)) - 10000;
                for (int unsigned i = 0; i < len; i++) begin
                    x = pick_coord(style, x);
                    y = pick_coord(style, y);
                    send_waypoint(mk_wp(x, y, $urandom_range(0, 6) == 0,
                                        $urandom_range(0, 6) == 0, i == len - 1));
                end
                phase_points += len;
            end
            drain_results();
        end
    endtask

    // Receiver: random stall runs, calm stretches, and a counted hold-off on request.
    initial begin
        int unsigned run_left;
        logic        run_val;
        run_left = 0;
        run_val = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles != 0) begin
                rx_hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_val = !run_val;
                    if (run_val) run_left = pick_gap_len();
                    else run_left = ($urandom_range(0, 9) == 0) ?
                                    $urandom_range(50, 300) : $urandom_range(1, 10);
                end
                run_left--;
                i_out_stall <= run_val;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_stops.size() == 0) begin
                note_failure($sformatf("unexpected result word: dist %0d kind %0d vel %0d",
                             o_out_word.stop_distance, o_out_word.stop_kind,
                             o_out_word.target_velocity));
            end else begin
                want = pending_stops.pop_front();
                paths_checked++;
                kinds_seen[want.stop_kind]++;
                if (o_out_word.stop_distance !== want.stop_distance ||
                    o_out_word.stop_kind !== want.stop_kind ||
                    o_out_word.target_velocity !== want.target_velocity)
                    note_failure($sformatf(
                        "path %0d: want dist %0d kind %0d vel %0d, got dist %0d kind %0d vel %0d",
                        paths_checked, want.stop_distance, want.stop_kind,
                        want.target_velocity, o_out_word.stop_distance,
                        o_out_word.stop_kind, o_out_word.target_velocity));
            end
        end
    end

    initial begin
        int unsigned waited;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_stop_rules();
        test_length_saturation();
        test_backpressure();
        test_long_paths();
        test_random_paths();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_stops.size() != 0 && waited < FINAL_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_stops.size() != 0) begin
            void'(pending_stops.pop_front());
            note_failure("expected result never arrived");
        end

        $display("Run covered %0d waypoints in %0d checked paths, incl. saturated length,",
                 sent_count, paths_checked);
        $display("a %0d point path and a long output hold; none/signal/temp/obstacle: %0d/%0d/%0d/%0d",
                 LONG_POINTS, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
        if (fail_count == 0) begin
            $display("path_stop_point_distance_unit verification clean");
        end else begin
            $display("path_stop_point_distance_unit verification failed");
        end
        $finish;
    end

endmodule
